### rtl/floyd_steinberg_mono_packer_assert.svh
// Assertion macros for the mono packer.
// Needs i_clk and i_rst_n in the including scope.
`ifndef FLOYD_STEINBERG_MONO_PACKER_ASSERT_SVH
`define FLOYD_STEINBERG_MONO_PACKER_ASSERT_SVH

// Same-cycle implication.
`define FSMP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define FSMP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/fsmp_pkg.sv
// Package for the mono packer: sizes, register indexes, error type.
// No dependencies.
package fsmp_pkg;

    localparam int MaxRowPixels = 2048;
    localparam int RowSlots     = MaxRowPixels + 2;
    localparam int ColW         = $clog2(MaxRowPixels + 1);
    localparam int AddrW        = $clog2(RowSlots);
    localparam int ErrW         = 10;
    localparam int CfgIdxW      = 3;
    localparam int CfgDataW     = 16;

    typedef logic signed [ErrW-1:0] t_err;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_RED_SHIFT   = 3'd0,
        CFG_GREEN_SHIFT = 3'd1,
        CFG_BLUE_SHIFT  = 3'd2,
        CFG_RED_MAX     = 3'd3,
        CFG_GREEN_MAX   = 3'd4,
        CFG_BLUE_MAX    = 3'd5
    } t_cfg_reg;

endpackage

### rtl/fsmp_if.sv
// Channel interfaces of the mono packer: pixel in, byte out, config write.
// Depends on fsmp_pkg.
interface fsmp_px_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_word;
    logic        rect_first;
    logic        row_last;
    logic        rect_last;
    modport source (output valid, pixel_word, rect_first, row_last, rect_last, input ready);
    modport sink   (input valid, pixel_word, rect_first, row_last, rect_last, output ready);
endinterface

interface fsmp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       byte_row_last;
    logic       byte_rect_last;
    logic       row_overflow;
    modport source (output valid, packed_byte, byte_row_last, byte_rect_last, row_overflow,
                    input ready);
    modport sink   (input valid, packed_byte, byte_row_last, byte_rect_last, row_overflow,
                    output ready);
endinterface

interface fsmp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fsmp_pkg::CfgIdxW-1:0]  index;
    logic [fsmp_pkg::CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/floyd_steinberg_mono_packer.sv
// Floyd-Steinberg 1bpp dither and bit packer, top level.
// Depends on fsmp_pkg, fsmp_if.sv and floyd_steinberg_mono_packer_assert.svh.
//
//  channel | dir | payload                                            | beat
//  i_cfg   | in  | index, data                                        | one register write
//  i_px    | in  | pixel_word, rect_first, row_last, rect_last        | one pixel
//  o_byte  | out | packed_byte, byte_row_last, byte_rect_last, row_overflow | one byte
//
// A pixel passes accept, 8 steps of the radix-2 channel scaler (three dividers
// in parallel, one per channel), luma/error fetch, then the line-store update.
// Error rows live in two ping-pong RAMs (one read, one write per pixel); a
// fill count and two tail registers replace any clearing, so no sweep after reset.
// Config is always ready. A full output register stalls only the final step;
// a new pixel is taken while a byte still waits.
`include "floyd_steinberg_mono_packer_assert.svh"

module floyd_steinberg_mono_packer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fsmp_cfg_if.sink      i_cfg,
    fsmp_px_if.sink       i_px,
    fsmp_byte_if.source   o_byte
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_LUMA, S_EXEC} t_state;

    // config registers
    logic [4:0]  r_shift [3];
    logic [15:0] r_max   [3];

    // per-pixel work registers
    t_state      r_state;
    logic [2:0]  r_step;
    logic [15:0] r_rem  [3];
    logic [7:0]  r_lo   [3];
    logic [7:0]  r_q    [3];
    logic [7:0]  r_c    [3];
    logic        r_byp  [3];
    logic        r_zero [3];
    logic        r_row_last;
    logic        r_rect_last;
    logic [7:0]  r_luma;
    logic signed [10:0] r_err_in;
    logic        r_in_store;

    // row state
    logic [fsmp_pkg::ColW-1:0]  r_col;
    logic [fsmp_pkg::ColW-1:0]  r_fill;     // entries valid in current-row RAM
    fsmp_pkg::t_err   r_tail0;    // current row at index r_fill
    fsmp_pkg::t_err   r_tail1;    // current row at index r_fill+1
    fsmp_pkg::t_err   r_carry;    // 7/16 from left neighbor
    fsmp_pkg::t_err   r_acc_a;    // next row at r_col, partial
    fsmp_pkg::t_err   r_acc_b;    // next row at r_col+1, partial
    logic [7:0]       r_bits;
    logic [2:0]       r_bitpos;
    logic             r_ovf;
    logic             r_cur_bank;

    // output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_row_last;
    logic       r_out_rect_last;
    logic       r_out_ovf;

    // line store
    fsmp_pkg::t_err mem0 [fsmp_pkg::RowSlots];
    fsmp_pkg::t_err mem1 [fsmp_pkg::RowSlots];
    fsmp_pkg::t_err r_rd0;
    fsmp_pkg::t_err r_rd1;

    logic             px_acc;
    logic             rd_en;
    logic [fsmp_pkg::AddrW-1:0] rd_addr;
    logic [fsmp_pkg::ColW-1:0]  rd_col;
    logic             wr_en;
    logic [fsmp_pkg::AddrW-1:0] wr_addr;
    fsmp_pkg::t_err   wr_data;
    logic             go;
    logic             row_end;

    logic [15:0] ch_c   [3];
    logic [16:0] div_t  [3];
    logic        div_b  [3];
    logic [15:0] div_r  [3];
    logic [7:0]  ch_v   [3];
    logic [15:0] luma_sum;
    logic [fsmp_pkg::ColW:0]    rd_idx;
    fsmp_pkg::t_err   cur_val;

    logic signed [11:0] v_raw;
    logic [7:0]         v_clamp;
    logic               pix_bit;
    logic signed [8:0]  e;
    logic signed [12:0] e_x;
    logic signed [12:0] w7, w5, w3;
    fsmp_pkg::t_err     p7, p5, p3, p1;
    fsmp_pkg::t_err     n_acc_a, n_acc_b;
    logic [7:0]         n_bits;
    logic [fsmp_pkg::ColW-1:0]    n_col;

    assign i_cfg.ready = 1'b1;
    assign i_px.ready  = (r_state == S_IDLE);
    assign px_acc      = i_px.valid && i_px.ready;

    assign o_byte.valid          = r_out_valid;
    assign o_byte.packed_byte    = r_out_byte;
    assign o_byte.byte_row_last  = r_out_row_last;
    assign o_byte.byte_rect_last = r_out_rect_last;
    assign o_byte.row_overflow   = r_out_ovf;

    // channel extract and one divider step per channel
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ch_c[k]  = 16'(i_px.pixel_word >> r_shift[k]) & r_max[k];
            div_t[k] = {r_rem[k], r_lo[k][7]};
            div_b[k] = (div_t[k] >= {1'b0, r_max[k]});
            div_r[k] = div_b[k] ? 16'(div_t[k] - {1'b0, r_max[k]}) : div_t[k][15:0];
            ch_v[k]  = r_zero[k] ? 8'd0 : (r_byp[k] ? r_c[k] : r_q[k]);
        end
        luma_sum = 16'(8'd77 * {8'd0, ch_v[0]}) + 16'(8'd150 * {8'd0, ch_v[1]})
                 + 16'(8'd29 * {8'd0, ch_v[2]});
    end

    // current-row error at column+1: RAM below fill, tails just past it, else zero
    always_comb begin
        rd_idx = {1'b0, r_col} + (fsmp_pkg::ColW+1)'(1);
        if (rd_idx < {1'b0, r_fill}) begin
            cur_val = r_cur_bank ? r_rd1 : r_rd0;
        end else if (rd_idx == {1'b0, r_fill}) begin
            cur_val = r_tail0;
        end else if (rd_idx == {1'b0, r_fill} + (fsmp_pkg::ColW+1)'(1)) begin
            cur_val = r_tail1;
        end else begin
            cur_val = '0;
        end
    end

    // dither and diffuse
    always_comb begin
        v_raw = $signed({4'd0, r_luma}) + 12'(r_err_in);
        if (v_raw < 0) begin
            v_clamp = 8'd0;
        end else if (v_raw > 12'sd255) begin
            v_clamp = 8'd255;
        end else begin
            v_clamp = v_raw[7:0];
        end
        pix_bit = v_clamp[7];
        e   = pix_bit ? ($signed({1'b0, v_clamp}) - 9'sd255) : $signed({1'b0, v_clamp});
        e_x = 13'(e);
        w7  = e_x * 13'sd7;
        w5  = e_x * 13'sd5;
        w3  = e_x * 13'sd3;
        p7  = 10'(w7 >>> 4);
        p5  = 10'(w5 >>> 4);
        p3  = 10'(w3 >>> 4);
        p1  = 10'(e_x >>> 4);
        n_acc_a = r_in_store ? (r_acc_b + p5) : r_acc_a;
        n_acc_b = r_in_store ? p1 : r_acc_b;
        n_bits  = r_bits | (pix_bit ? (8'h80 >> r_bitpos) : 8'h00);
        n_col   = r_in_store ? (r_col + fsmp_pkg::ColW'(1)) : r_col;
    end

    assign go      = (r_state == S_EXEC) && (!r_out_valid || o_byte.ready);
    assign row_end = r_row_last || r_rect_last;

    assign rd_col  = i_px.rect_first ? '0 : r_col;
    assign rd_addr = fsmp_pkg::AddrW'(rd_col) + fsmp_pkg::AddrW'(1);
    assign rd_en   = px_acc;
    assign wr_en   = go && r_in_store;
    assign wr_addr = fsmp_pkg::AddrW'(r_col);
    assign wr_data = r_acc_a + p3;

    // bank 0 / bank 1: the current row is read, the other bank is written
    always_ff @(posedge i_clk) begin
        if (wr_en && r_cur_bank) begin
            mem0[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd0 <= mem0[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !r_cur_bank) begin
            mem1[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd1 <= mem1[rd_addr];
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift[0] <= 5'd16;
            r_shift[1] <= 5'd8;
            r_shift[2] <= 5'd0;
            r_max[0]   <= 16'd255;
            r_max[1]   <= 16'd255;
            r_max[2]   <= 16'd255;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (fsmp_pkg::t_cfg_reg'(i_cfg.index))
                fsmp_pkg::CFG_RED_SHIFT:   r_shift[0] <= i_cfg.data[4:0];
                fsmp_pkg::CFG_GREEN_SHIFT: r_shift[1] <= i_cfg.data[4:0];
                fsmp_pkg::CFG_BLUE_SHIFT:  r_shift[2] <= i_cfg.data[4:0];
                fsmp_pkg::CFG_RED_MAX:     r_max[0]   <= i_cfg.data;
                fsmp_pkg::CFG_GREEN_MAX:   r_max[1]   <= i_cfg.data;
                fsmp_pkg::CFG_BLUE_MAX:    r_max[2]   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // datapath payload, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                for (int k = 0; k < 3; k++) begin
                    // c*255 = (c<<8)-c; quotient fits 8 bits so start from the top 16
                    r_rem[k]  <= 16'(({ch_c[k], 8'h00} - {8'h00, ch_c[k]}) >> 8);
                    r_lo[k]   <= 8'({ch_c[k], 8'h00} - {8'h00, ch_c[k]});
                    r_c[k]    <= ch_c[k][7:0];
                    r_byp[k]  <= (r_max[k] == 16'd255);
                    r_zero[k] <= (r_max[k] == 16'd0);
                end
                r_row_last  <= i_px.row_last;
                r_rect_last <= i_px.rect_last;
            end
            S_DIV: begin
                for (int k = 0; k < 3; k++) begin
                    r_rem[k] <= div_r[k];
                    r_lo[k]  <= {r_lo[k][6:0], 1'b0};
                    r_q[k]   <= {r_q[k][6:0], div_b[k]};
                end
            end
            S_LUMA: begin
                r_luma     <= luma_sum[15:8];
                r_in_store <= (r_col < fsmp_pkg::ColW'(fsmp_pkg::MaxRowPixels));
                r_err_in   <= (r_col < fsmp_pkg::ColW'(fsmp_pkg::MaxRowPixels))
                              ? (11'(cur_val) + 11'(r_carry)) : 11'sd0;
            end
            default: ;
        endcase
        if (go) begin
            r_out_byte      <= n_bits;
            r_out_row_last  <= row_end;
            r_out_rect_last <= r_rect_last;
            r_out_ovf       <= r_ovf || !r_in_store;
        end
    end

    // control and row state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_col       <= '0;
            r_fill      <= '0;
            r_tail0     <= '0;
            r_tail1     <= '0;
            r_carry     <= '0;
            r_acc_a     <= '0;
            r_acc_b     <= '0;
            r_bits      <= '0;
            r_bitpos    <= '0;
            r_ovf       <= 1'b0;
            r_cur_bank  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_byte.valid && o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (px_acc) begin
                        r_state <= S_DIV;
                        r_step  <= '0;
                        if (i_px.rect_first) begin
                            // rectangle start: both rows read as zero, partial byte dropped
                            r_col    <= '0;
                            r_fill   <= '0;
                            r_tail0  <= '0;
                            r_tail1  <= '0;
                            r_carry  <= '0;
                            r_acc_a  <= '0;
                            r_acc_b  <= '0;
                            r_bits   <= '0;
                            r_bitpos <= '0;
                            r_ovf    <= 1'b0;
                        end
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= S_LUMA;
                    end
                end
                S_LUMA: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (go) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= row_end || (r_bitpos == 3'd7);
                        if (row_end) begin
                            // next row becomes current; its last two entries sit in tails
                            r_cur_bank <= !r_cur_bank;
                            r_fill     <= n_col;
                            r_tail0    <= n_acc_a;
                            r_tail1    <= n_acc_b;
                            r_col      <= '0;
                            r_carry    <= '0;
                            r_acc_a    <= '0;
                            r_acc_b    <= '0;
                            r_bits     <= '0;
                            r_bitpos   <= '0;
                            r_ovf      <= 1'b0;
                        end else begin
                            r_col   <= n_col;
                            r_carry <= r_in_store ? p7 : r_carry;
                            r_acc_a <= n_acc_a;
                            r_acc_b <= n_acc_b;
                            r_ovf   <= r_ovf || !r_in_store;
                            if (r_bitpos == 3'd7) begin
                                r_bits   <= '0;
                                r_bitpos <= '0;
                            end else begin
                                r_bits   <= n_bits;
                                r_bitpos <= r_bitpos + 3'd1;
                            end
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `FSMP_ASSERT_NXT(a_accept_starts_div, px_acc, r_state == S_DIV)
    `FSMP_ASSERT_IMP(a_col_bounded, 1'b1, r_col <= fsmp_pkg::ColW'(fsmp_pkg::MaxRowPixels))
    `FSMP_ASSERT_NXT(a_bank_holds_midrow, go && !row_end, r_cur_bank == $past(r_cur_bank))
    `FSMP_ASSERT_IMP(a_no_write_while_idle, r_state != S_EXEC, !wr_en)

endmodule

### sim/testbench.sv
// Self-checking bench for floyd_steinberg_mono_packer: dithers pixel streams
// through the block and checks every packed byte against an in-bench predictor.
// Depends on fsmp_pkg, fsmp_if.sv and the block's RTL.
module testbench;

    localparam int CycleLimit = 600000;
    localparam int SettleCycles = 40;   // margin on top of one pixel's processing

    typedef struct {
        logic [31:0] word;
        bit          first;
        bit          row_end;
        bit          rect_end;
        bit          wait_drain;   // sender holds this pixel until all bytes are back
    } t_pixel;

    typedef struct {
        logic [7:0] bits;
        bit         row_end;
        bit         rect_end;
        bit         overflow;
    } t_byte;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fsmp_cfg_if  cfg_bus ();
    fsmp_px_if   px_bus ();
    fsmp_byte_if byte_bus ();

    floyd_steinberg_mono_packer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus.sink),
        .i_px    (px_bus.sink),
        .o_byte  (byte_bus.source)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: register copy, both error rows, row progress.
    logic [4:0]  shift_q [3];
    logic [15:0] max_q   [3];
    int          err_cur [fsmp_pkg::RowSlots];
    int          err_nxt [fsmp_pkg::RowSlots];
    int          col_cnt;
    logic [7:0]  bit_acc;
    int          bit_pos;
    bit          ovf_seen;

    t_pixel pixel_queue [$];
    t_byte  pending_bytes [$];
    t_pixel cur_pixel;

    int send_idle_pct = 12;
    int recv_idle_pct = 60;
    int hold_at = 300;          // pixel count at which the receiver stalls long
    int hold_left = 0;
    bit hold_done = 0;
    int cycles = 0;
    int pixels_sent = 0;
    int bytes_checked = 0;
    int overflow_bytes = 0;
    int fail_count = 0;

    function automatic int scale_channel(logic [31:0] word, int k);
        logic [31:0] c;
        c = (word >> shift_q[k]) & {16'h0, max_q[k]};
        if (max_q[k] == 16'd0)
            return 0;
        if (max_q[k] != 16'd255)
            c = (c * 32'd255) / {16'h0, max_q[k]};
        return int'(c);
    endfunction

    function automatic void clear_rows();
        foreach (err_cur[i]) begin
            err_cur[i] = 0;
            err_nxt[i] = 0;
        end
    endfunction

    function automatic void restart_row();
        col_cnt = 0;
        bit_acc = 8'h00;
        bit_pos = 0;
        ovf_seen = 0;
    endfunction

    // Dither one pixel and queue the byte it completes, if any.
    function automatic void dither_pixel(t_pixel p);
        int    luma;
        int    val;
        int    err;
        bit    stored;
        t_byte b;
        if (p.first) begin
            clear_rows();
            restart_row();
        end
        luma = (77 * scale_channel(p.word, 0) + 150 * scale_channel(p.word, 1)
                + 29 * scale_channel(p.word, 2)) >> 8;
        stored = col_cnt < fsmp_pkg::MaxRowPixels;
        if (!stored)
            ovf_seen = 1;
        val = luma + (stored ? err_cur[col_cnt + 1] : 0);
        if (val < 0) val = 0;
        if (val > 255) val = 255;
        if (val >= 128) begin
            bit_acc[7 - bit_pos] = 1'b1;
            err = val - 255;
        end else begin
            err = val;
        end
        if (stored) begin
            // floor division by 16 via arithmetic shift
            err_cur[col_cnt + 2] += (err * 7) >>> 4;
            err_nxt[col_cnt]     += (err * 3) >>> 4;
            err_nxt[col_cnt + 1] += (err * 5) >>> 4;
            err_nxt[col_cnt + 2] += err >>> 4;
            col_cnt++;
        end
        if (p.row_end || p.rect_end) begin
            b = '{bit_acc, 1'b1, p.rect_end, ovf_seen};
            pending_bytes.push_back(b);
            err_cur = err_nxt;
            foreach (err_nxt[i]) err_nxt[i] = 0;
            restart_row();
        end else if (bit_pos == 7) begin
            b = '{bit_acc, 1'b0, 1'b0, ovf_seen};
            pending_bytes.push_back(b);
            bit_acc = 8'h00;
            bit_pos = 0;
        end else begin
            bit_pos++;
        end
    endfunction

    // Pixel driver: next beat is offered once the current one is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            px_bus.valid <= 1'b0;
        end else begin
            if (px_bus.valid && px_bus.ready) begin
                dither_pixel(cur_pixel);
                pixels_sent++;
            end
            if (!px_bus.valid || px_bus.ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct
                        && !(pixel_queue[0].wait_drain && pending_bytes.size() != 0)) begin
                    cur_pixel = pixel_queue.pop_front();
                    px_bus.valid      <= 1'b1;
                    px_bus.pixel_word <= cur_pixel.word;
                    px_bus.rect_first <= cur_pixel.first;
                    px_bus.row_last   <= cur_pixel.row_end;
                    px_bus.rect_last  <= cur_pixel.rect_end;
                end else begin
                    px_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Byte monitor: checks each beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_byte want;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("floyd_steinberg_mono_packer test failed");
            $finish;
        end
        if (!i_rst_n) begin
            byte_bus.ready <= 1'b0;
        end else begin
            if (byte_bus.valid && byte_bus.ready) begin
                if (pending_bytes.size() == 0) begin
                    $error("unexpected byte %h", byte_bus.packed_byte);
                    fail_count++;
                end else begin
                    want = pending_bytes.pop_front();
                    bytes_checked++;
                    if (want.overflow) overflow_bytes++;
                    if (byte_bus.packed_byte !== want.bits) begin
                        $error("packed_byte exp %h got %h", want.bits, byte_bus.packed_byte);
                        fail_count++;
                    end
                    if (byte_bus.byte_row_last !== want.row_end) begin
                        $error("byte_row_last exp %b got %b", want.row_end,
                               byte_bus.byte_row_last);
                        fail_count++;
                    end
                    if (byte_bus.byte_rect_last !== want.rect_end) begin
                        $error("byte_rect_last exp %b got %b", want.rect_end,
                               byte_bus.byte_rect_last);
                        fail_count++;
                    end
                    if (byte_bus.row_overflow !== want.overflow) begin
                        $error("row_overflow exp %b got %b", want.overflow,
                               byte_bus.row_overflow);
                        fail_count++;
                    end
                end
            end
            // one long stall so the block backs up into its input
            if (!hold_done && pixels_sent >= hold_at) begin
                hold_done <= 1'b1;
                hold_left <= 500;
                byte_bus.ready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                byte_bus.ready <= 1'b0;
            end else begin
                byte_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic settle();
        do @(posedge i_clk);
        while (pixel_queue.size() != 0 || px_bus.valid || pending_bytes.size() != 0);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Writes all six registers in one burst; valid stays high in between.
    task automatic program_regs(logic [4:0] rs, logic [4:0] gs, logic [4:0] bs,
                                logic [15:0] rm, logic [15:0] gm, logic [15:0] bm);
        logic [15:0] vals [6];
        vals = '{16'(rs), 16'(gs), 16'(bs), rm, gm, bm};
        for (int i = 0; i < 6; i++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= fsmp_pkg::t_cfg_reg'(i);
            cfg_bus.data  <= vals[i];
            do @(posedge i_clk);
            while (!cfg_bus.ready);
            case (fsmp_pkg::t_cfg_reg'(i))
                fsmp_pkg::CFG_RED_SHIFT:   shift_q[0] = vals[i][4:0];
                fsmp_pkg::CFG_GREEN_SHIFT: shift_q[1] = vals[i][4:0];
                fsmp_pkg::CFG_BLUE_SHIFT:  shift_q[2] = vals[i][4:0];
                fsmp_pkg::CFG_RED_MAX:     max_q[0] = vals[i];
                fsmp_pkg::CFG_GREEN_MAX:   max_q[1] = vals[i];
                fsmp_pkg::CFG_BLUE_MAX:    max_q[2] = vals[i];
                default: ;
            endcase
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic void add_pixel(logic [31:0] w, bit f, bit rl, bit ql);
        t_pixel p;
        p = '{w, f, rl, ql, 1'b0};
        pixel_queue.push_back(p);
    endfunction

    function automatic logic [31:0] rand_word();
        logic [7:0] g;
        if ($urandom_range(1))
            return $urandom();
        g = 8'($urandom_range(100, 156));   // near the threshold, errors matter
        return {8'($urandom()), g, g, g};
    endfunction

    // Random rectangles, mostly well formed, a few broken on purpose.
    function automatic void add_rects(int count);
        int     added;
        int     width;
        int     rows;
        bit     last;
        t_pixel p;
        added = 0;
        while (added < count) begin
            width = ($urandom_range(9) == 0) ? $urandom_range(25, 70) : $urandom_range(1, 20);
            rows = $urandom_range(1, 4);
            for (int r = 0; r < rows; r++) begin
                for (int c = 0; c < width; c++) begin
                    last = (r == rows - 1) && (c == width - 1);
                    p.word = rand_word();
                    p.first = (r == 0 && c == 0) || ($urandom_range(60) == 0);
                    p.row_end = (c == width - 1) && !(last && $urandom_range(5) == 0);
                    p.rect_end = last;
                    p.wait_drain = (r == 0 && c == 0 && $urandom_range(15) == 0);
                    pixel_queue.push_back(p);
                    added++;
                end
            end
        end
    endfunction

    initial begin
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data = '0;
        px_bus.valid = 1'b0;
        px_bus.pixel_word = '0;
        px_bus.rect_first = 1'b0;
        px_bus.row_last = 1'b0;
        px_bus.rect_last = 1'b0;
        byte_bus.ready = 1'b0;
        shift_q = '{5'd16, 5'd8, 5'd0};
        max_q = '{16'd255, 16'd255, 16'd255};
        clear_rows();
        restart_row();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes under reset config.
        add_pixel(32'hFFFF_FFFF, 1, 0, 0);           // all white
        add_pixel(32'h0000_0000, 0, 0, 0);           // all black
        add_pixel(32'h0080_8080, 0, 0, 0);           // right at threshold
        add_pixel(32'h007F_7F7F, 0, 0, 0);           // just below
        for (int i = 0; i < 4; i++) add_pixel(32'h0060_6060, 0, i == 3, 0);  // 8 wide row
        for (int i = 0; i < 9; i++) add_pixel(32'hFF90_9090, 0, i == 8, 0);  // row of 9
        add_pixel(32'h00C0_C0C0, 0, 1, 0);           // one-pixel row, errors carry on
        add_pixel(32'h0040_4040, 0, 0, 0);
        add_pixel(32'h00FF_FFFF, 1, 0, 0);           // new rect drops partial byte
        add_pixel(32'h00A0_A0A0, 0, 0, 1);           // rect end without row end
        settle();

        // Long row past the line store, single rect.
        for (int i = 0; i < fsmp_pkg::MaxRowPixels + 5; i++)
            add_pixel(rand_word(), i == 0, 0, i == fsmp_pkg::MaxRowPixels + 4);
        add_pixel(32'h0080_8080, 1, 1, 1);
        settle();

        for (int phase = 0; phase < 5; phase++) begin
            send_idle_pct = (phase % 3 == 0) ? 12 : (phase % 3 == 1) ? 60 : 0;
            recv_idle_pct = (phase % 3 == 0) ? 60 : (phase % 3 == 1) ? 12 : 0;
            case (phase)
                0: program_regs(5'd0, 5'd0, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                1: program_regs(5'd31, 5'd24, 5'd5, 16'd1, 16'd0, 16'd31);
                2: program_regs(5'($urandom()), 5'($urandom()), 5'($urandom()),
                                16'($urandom()), 16'($urandom_range(1, 300)),
                                16'($urandom()));
                3: program_regs(5'd11, 5'd5, 5'd0, 16'd31, 16'd63, 16'd31);
                default: program_regs(5'd16, 5'd8, 5'd0, 16'd255, 16'd255, 16'd255);
            endcase
            add_rects(160);
            settle();
        end

        $display("covered %0d pixels, %0d bytes checked (%0d flagged overflow)",
                 pixels_sent, bytes_checked, overflow_bytes);
        $display("six register settings incl. extremes, long stall and drain pauses");
        if (fail_count == 0 && pending_bytes.size() == 0)
            $display("floyd_steinberg_mono_packer test passed");
        else
            $display("floyd_steinberg_mono_packer test failed");
        $finish;
    end

endmodule
